[rtl/bwts_pkg.sv]
`timescale 1ns / 1ps

package bwts_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_SIDE_DEF   = 256;
	localparam int TEXEL_BITS_DEF = 16;

	// Fixed field widths
	localparam int FRAC_W     = 16;
	localparam int IDX_W      = 16;
	localparam int VAL_W      = 16;
	localparam int COORD_IN_W = 32;
	localparam int OUT_W      = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 9;

	// Slave tdata layout, lowest field first
	localparam int IDX_LSB   = 0;
	localparam int VAL_LSB   = IDX_LSB + IDX_W;
	localparam int U_LSB     = VAL_LSB + VAL_W;
	localparam int V_LSB     = U_LSB + COORD_IN_W;
	localparam int S_TDATA_W = V_LSB + COORD_IN_W;

	// Result queue
	localparam int OFIFO_DEPTH = 16;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_TEX_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TEX_HEIGHT = 2'd1;

	// Neighbor taps of one sample
	localparam int NUM_TAPS = 4;
	localparam int TAP_00   = 0;   // row y0, column x0
	localparam int TAP_10   = 1;   // row y0, column x1
	localparam int TAP_01   = 2;   // row y1, column x0
	localparam int TAP_11   = 3;   // row y1, column x1

	typedef enum logic [0:0] {
		REQ_WRITE  = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	typedef struct packed {
		logic valid;
		req_t kind;
	} ctl_t;

	typedef struct packed {
		logic nonempty;
		logic full;
	} ofifo_stat_t;

endpackage

[rtl/bwts_addr.sv]
`timescale 1ns / 1ps

module bwts_addr #(
	parameter int MAX_SIDE   = bwts_pkg::MAX_SIDE_DEF,
	parameter int TEXEL_BITS = bwts_pkg::TEXEL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bwts_pkg::ctl_t                        in_ctl,
	input  logic [bwts_pkg::IDX_W-1:0]            texel_index,
	input  logic signed [bwts_pkg::VAL_W-1:0]     texel_value,
	input  logic [bwts_pkg::FRAC_W-1:0]           u_frac,
	input  logic [bwts_pkg::FRAC_W-1:0]           v_frac,
	input  logic [$clog2(MAX_SIDE+1)-1:0]         width,
	input  logic [$clog2(MAX_SIDE+1)-1:0]         height,
	output bwts_pkg::ctl_t                        ctl_s3,
	output logic                                  wr_en,
	output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  wr_addr,
	output logic signed [TEXEL_BITS-1:0]          wr_data,
	output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  rd_addr [bwts_pkg::NUM_TAPS],
	output logic [bwts_pkg::FRAC_W-1:0]           dx_s3,
	output logic [bwts_pkg::FRAC_W-1:0]           dy_s3
);

	localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
	localparam int COORD_W     = $clog2(MAX_SIDE);
	localparam int ADDR_W      = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int PROD_W      = bwts_pkg::FRAC_W + SIDE_W;
	localparam int ROW_W       = COORD_W + SIDE_W;

	// stage 1: scaled coordinates
	bwts_pkg::ctl_t              ctl_s1;
	logic [PROD_W-1:0]           px_s1, py_s1;
	logic [ADDR_W-1:0]           waddr_s1;
	logic                        wok_s1;
	logic signed [TEXEL_BITS-1:0] wval_s1;

	// stage 2: cell corners and weights
	bwts_pkg::ctl_t              ctl_s2;
	logic [COORD_W-1:0]          x0_s2, x1_s2, y0_s2, y1_s2;
	logic [bwts_pkg::FRAC_W-1:0] dx_s2, dy_s2;
	logic [ADDR_W-1:0]           waddr_s2;
	logic                        wok_s2;
	logic signed [TEXEL_BITS-1:0] wval_s2;

	// stage 3: row bases
	logic [ADDR_W-1:0]           row0_s3, row1_s3;
	logic [COORD_W-1:0]          x0_s3, x1_s3;
	logic [ADDR_W-1:0]           waddr_s3;
	logic                        wok_s3;
	logic signed [TEXEL_BITS-1:0] wval_s3;

	logic [COORD_W-1:0]          x0_d, y0_d, x1_d, y1_d;
	logic [SIDE_W:0]             x0_inc, y0_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s1    <= PROD_W'(u_frac) * PROD_W'(width);
		py_s1    <= PROD_W'(v_frac) * PROD_W'(height);
		waddr_s1 <= ADDR_W'(texel_index);
		wok_s1   <= 32'(texel_index) < 32'(STORE_DEPTH);
		wval_s1  <= TEXEL_BITS'(texel_value);
	end

	// integer part picks the cell; the far neighbor wraps at the edge
	always_comb begin
		x0_d   = px_s1[bwts_pkg::FRAC_W +: COORD_W];
		y0_d   = py_s1[bwts_pkg::FRAC_W +: COORD_W];
		x0_inc = (SIDE_W+1)'(x0_d) + (SIDE_W+1)'(1);
		y0_inc = (SIDE_W+1)'(y0_d) + (SIDE_W+1)'(1);
		x1_d   = (x0_inc == (SIDE_W+1)'(width))  ? '0 : COORD_W'(x0_inc);
		y1_d   = (y0_inc == (SIDE_W+1)'(height)) ? '0 : COORD_W'(y0_inc);
	end

	always_ff @(posedge clk) begin
		x0_s2    <= x0_d;
		x1_s2    <= x1_d;
		y0_s2    <= y0_d;
		y1_s2    <= y1_d;
		dx_s2    <= px_s1[bwts_pkg::FRAC_W-1:0];
		dy_s2    <= py_s1[bwts_pkg::FRAC_W-1:0];
		waddr_s2 <= waddr_s1;
		wok_s2   <= wok_s1;
		wval_s2  <= wval_s1;
	end

	always_ff @(posedge clk) begin
		row0_s3  <= ADDR_W'(ROW_W'(y0_s2) * ROW_W'(width));
		row1_s3  <= ADDR_W'(ROW_W'(y1_s2) * ROW_W'(width));
		x0_s3    <= x0_s2;
		x1_s3    <= x1_s2;
		dx_s3    <= dx_s2;
		dy_s3    <= dy_s2;
		waddr_s3 <= waddr_s2;
		wok_s3   <= wok_s2;
		wval_s3  <= wval_s2;
	end

	assign rd_addr[bwts_pkg::TAP_00] = row0_s3 + ADDR_W'(x0_s3);
	assign rd_addr[bwts_pkg::TAP_10] = row0_s3 + ADDR_W'(x1_s3);
	assign rd_addr[bwts_pkg::TAP_01] = row1_s3 + ADDR_W'(x0_s3);
	assign rd_addr[bwts_pkg::TAP_11] = row1_s3 + ADDR_W'(x1_s3);

	assign wr_en   = ctl_s3.valid && (ctl_s3.kind == bwts_pkg::REQ_WRITE) && wok_s3;
	assign wr_addr = waddr_s3;
	assign wr_data = wval_s3;

endmodule

[rtl/bwts_store.sv]
`timescale 1ns / 1ps

module bwts_store #(
	parameter int MAX_SIDE   = bwts_pkg::MAX_SIDE_DEF,
	parameter int TEXEL_BITS = bwts_pkg::TEXEL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  wr_addr,
	input  logic signed [TEXEL_BITS-1:0]          wr_data,
	input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]  rd_addr [bwts_pkg::NUM_TAPS],
	output logic signed [TEXEL_BITS-1:0]          rd_data [bwts_pkg::NUM_TAPS]
);

	localparam int DEPTH = MAX_SIDE * MAX_SIDE;

	// One copy per tap: every write lands in all copies, each copy serves one read.
	for (genvar b = 0; b < bwts_pkg::NUM_TAPS; b++) begin : g_copy
		logic signed [TEXEL_BITS-1:0] mem [DEPTH];

		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[wr_addr] <= wr_data;
			end
			rd_data[b] <= mem[rd_addr[b]];
		end
	end

endmodule

[rtl/bwts_blend.sv]
`timescale 1ns / 1ps

module bwts_blend #(
	parameter int TEXEL_BITS = bwts_pkg::TEXEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bwts_pkg::ctl_t                    ctl_s3,
	input  logic [bwts_pkg::FRAC_W-1:0]       dx_s3,
	input  logic [bwts_pkg::FRAC_W-1:0]       dy_s3,
	input  logic signed [TEXEL_BITS-1:0]      texel_s4 [bwts_pkg::NUM_TAPS],
	output logic                              res_valid,
	output logic [bwts_pkg::OUT_W-1:0]        res_data
);

	localparam int T      = TEXEL_BITS;
	localparam int MUL_W  = T + bwts_pkg::FRAC_W + 2;
	localparam int WGT_W  = bwts_pkg::FRAC_W + 1;

	bwts_pkg::ctl_t ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	logic [bwts_pkg::FRAC_W-1:0] dx_s4, dy_s4, dy_s5, dy_s6;
	logic signed [T-1:0]         t00_s5, t01_s5;
	logic signed [MUL_W-1:0]     m0_s5, m1_s5;
	logic signed [T-1:0]         a0_s6, a1_s6, a0_s7;
	logic signed [MUL_W-1:0]     m2_s7;
	logic signed [T-1:0]         r_s8;

	logic signed [T:0]           diff0, diff1, diff2;
	logic signed [WGT_W-1:0]     wx, wy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	// a*(1-w) + b*w is rewritten as a + (b-a)*w; the floor stays exact
	assign diff0 = (T+1)'(texel_s4[bwts_pkg::TAP_10]) - (T+1)'(texel_s4[bwts_pkg::TAP_00]);
	assign diff1 = (T+1)'(texel_s4[bwts_pkg::TAP_11]) - (T+1)'(texel_s4[bwts_pkg::TAP_01]);
	assign wx    = $signed({1'b0, dx_s4});
	assign diff2 = (T+1)'(a1_s6) - (T+1)'(a0_s6);
	assign wy    = $signed({1'b0, dy_s6});

	always_ff @(posedge clk) begin
		dx_s4  <= dx_s3;
		dy_s4  <= dy_s3;

		m0_s5  <= MUL_W'(diff0) * MUL_W'(wx);
		m1_s5  <= MUL_W'(diff1) * MUL_W'(wx);
		t00_s5 <= texel_s4[bwts_pkg::TAP_00];
		t01_s5 <= texel_s4[bwts_pkg::TAP_01];
		dy_s5  <= dy_s4;

		a0_s6  <= T'(MUL_W'(t00_s5) + (m0_s5 >>> bwts_pkg::FRAC_W));
		a1_s6  <= T'(MUL_W'(t01_s5) + (m1_s5 >>> bwts_pkg::FRAC_W));
		dy_s6  <= dy_s5;

		m2_s7  <= MUL_W'(diff2) * MUL_W'(wy);
		a0_s7  <= a0_s6;

		r_s8   <= T'(MUL_W'(a0_s7) + (m2_s7 >>> bwts_pkg::FRAC_W));
	end

	assign res_valid = ctl_s8.valid && (ctl_s8.kind == bwts_pkg::REQ_SAMPLE);
	assign res_data  = bwts_pkg::OUT_W'(r_s8);

endmodule

[rtl/bwts_ofifo.sv]
`timescale 1ns / 1ps

module bwts_ofifo #(
	parameter int DEPTH = bwts_pkg::OFIFO_DEPTH,
	parameter int W     = bwts_pkg::OUT_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [W-1:0]          push_data,
	input  logic                  pop,
	output logic [W-1:0]          head_data,
	output bwts_pkg::ofifo_stat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_data     = slot_q[rd_ptr_q];
	assign stat.nonempty = (count_q != '0);
	assign stat.full     = (count_q == CNT_W'(DEPTH));

endmodule

[rtl/bilinear_wrap_texel_sampler.sv]
`timescale 1ns / 1ps

// Each sample's result passes the blend stages and the result queue to m_tvalid.
// Throughput: one item per cycle; up to 16 samples (result queue depth) may be
// outstanding, so the rate holds as long as m_tready keeps up on average.
// Four copies of the texel memory serve the four neighbor reads in one cycle.
// Reset (arst_n low, asynchronous) clears pipeline valids, the queue and sets
// both sizes to min(MAX_SIDE, 256); texel memory stays undefined until written.

module bilinear_wrap_texel_sampler #(
	parameter int MAX_SIDE   = bwts_pkg::MAX_SIDE_DEF,
	parameter int TEXEL_BITS = bwts_pkg::TEXEL_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// Input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// tdata, low to high: texel_index[15:0], texel_value[31:16],
	//   u_coord[63:32], v_coord[95:64]
	input  logic [bwts_pkg::S_TDATA_W-1:0]       s_tdata,
	// tuser: req_type (0 write texel, 1 sample)
	input  logic [0:0]                           s_tuser,

	// Result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// tdata: sample_value[15:0]
	output logic [bwts_pkg::OUT_W-1:0]           m_tdata,

	// Configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bwts_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [bwts_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
	localparam int ADDR_W   = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int SIDE_RST = (MAX_SIDE < 256) ? MAX_SIDE : 256;
	localparam int CNT_W    = $clog2(bwts_pkg::OFIFO_DEPTH + 1);

	// Size registers hold the effective (clamped) side length.
	logic [SIDE_W-1:0]        width_q, height_q;
	logic [SIDE_W-1:0]        cfg_side;

	// Samples accepted whose results have not yet left the block.
	logic [CNT_W-1:0]         outstanding_q;

	bwts_pkg::ctl_t           in_ctl, ctl_s3;
	logic                     s_xfer, m_xfer, sample_xfer;

	logic                     wr_en;
	logic [ADDR_W-1:0]        wr_addr;
	logic signed [TEXEL_BITS-1:0] wr_data;
	logic [ADDR_W-1:0]        rd_addr [bwts_pkg::NUM_TAPS];
	logic signed [TEXEL_BITS-1:0] texel_s4 [bwts_pkg::NUM_TAPS];
	logic [bwts_pkg::FRAC_W-1:0] dx_s3, dy_s3;

	logic                     res_valid;
	logic [bwts_pkg::OUT_W-1:0] res_data;
	bwts_pkg::ofifo_stat_t    ofifo_stat;

	// ---------------------------------------------------------------
	// Configuration: zero reads as one, anything past the maximum side
	// reads as the maximum. Always ready.
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_side = SIDE_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_SIDE)) begin
			cfg_side = SIDE_W'(MAX_SIDE);
		end else begin
			cfg_side = SIDE_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(SIDE_RST);
			height_q <= SIDE_W'(SIDE_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				bwts_pkg::CFG_TEX_WIDTH:  width_q  <= cfg_side;
				bwts_pkg::CFG_TEX_HEIGHT: height_q <= cfg_side;
				default: ;  // drop writes to unknown registers
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Admission: a result slot is reserved for every sample at its input
	// transfer, so the fixed-latency pipeline never needs to stall.
	// ---------------------------------------------------------------
	assign s_tready    = outstanding_q < CNT_W'(bwts_pkg::OFIFO_DEPTH);
	assign s_xfer      = s_tvalid && s_tready;
	assign m_xfer      = m_tvalid && m_tready;
	assign sample_xfer = s_xfer && (bwts_pkg::req_t'(s_tuser[0]) == bwts_pkg::REQ_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (sample_xfer && !m_xfer) begin
			outstanding_q <= outstanding_q + CNT_W'(1);
		end else if (m_xfer && !sample_xfer) begin
			outstanding_q <= outstanding_q - CNT_W'(1);
		end
	end

	assign in_ctl.valid = s_xfer;
	assign in_ctl.kind  = bwts_pkg::req_t'(s_tuser[0]);

	// ---------------------------------------------------------------
	// Stages 1-3: wrap the coordinates, find the cell, form addresses.
	// Writes travel the same stages so they commit in order with reads.
	// ---------------------------------------------------------------
	bwts_addr #(
		.MAX_SIDE   (MAX_SIDE),
		.TEXEL_BITS (TEXEL_BITS)
	) u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ctl      (in_ctl),
		.texel_index (s_tdata[bwts_pkg::IDX_LSB +: bwts_pkg::IDX_W]),
		.texel_value ($signed(s_tdata[bwts_pkg::VAL_LSB +: bwts_pkg::VAL_W])),
		.u_frac      (s_tdata[bwts_pkg::U_LSB +: bwts_pkg::FRAC_W]),
		.v_frac      (s_tdata[bwts_pkg::V_LSB +: bwts_pkg::FRAC_W]),
		.width       (width_q),
		.height      (height_q),
		.ctl_s3      (ctl_s3),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.dx_s3       (dx_s3),
		.dy_s3       (dy_s3)
	);

	// ---------------------------------------------------------------
	// Texel memory: one write, four registered reads per cycle.
	// ---------------------------------------------------------------
	bwts_store #(
		.MAX_SIDE   (MAX_SIDE),
		.TEXEL_BITS (TEXEL_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (texel_s4)
	);

	// ---------------------------------------------------------------
	// Stages 5-8: blend along x, then along y, flooring each stage.
	// ---------------------------------------------------------------
	bwts_blend #(
		.TEXEL_BITS (TEXEL_BITS)
	) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s3    (ctl_s3),
		.dx_s3     (dx_s3),
		.dy_s3     (dy_s3),
		.texel_s4  (texel_s4),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

	// ---------------------------------------------------------------
	// Result queue decouples the pipeline from m_tready.
	// ---------------------------------------------------------------
	bwts_ofifo #(
		.DEPTH (bwts_pkg::OFIFO_DEPTH),
		.W     (bwts_pkg::OUT_W)
	) u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_data),
		.pop       (m_xfer),
		.head_data (m_tdata),
		.stat      (ofifo_stat)
	);

	assign m_tvalid = ofifo_stat.nonempty;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= CNT_W'(bwts_pkg::OFIFO_DEPTH))
		else $error("outstanding sample count exceeds result queue depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!ofifo_stat.full || m_xfer))
		else $error("result pushed into a full queue");

	a_result_owed: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer |-> (outstanding_q != '0))
		else $error("result transfer without an outstanding sample");

	a_no_write_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (ctl_s3.kind == bwts_pkg::REQ_WRITE) && !res_valid ||
			(ctl_s3.kind == bwts_pkg::REQ_WRITE))
		else $error("texel write issued from a sample slot");

endmodule

[sim/tb_bilinear_wrap_texel_sampler.sv]
`timescale 1ns / 1ps

module tb_bilinear_wrap_texel_sampler;

	localparam int MAX_SIDE      = bwts_pkg::MAX_SIDE_DEF;
	localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
	localparam int ITEM_TARGET   = 720;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 20;
	localparam int QUIET_LIMIT   = 1000;  // cycles with no transfer on any channel

	// Register indexes the sampler must ignore
	localparam logic [bwts_pkg::CFG_ADDR_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [bwts_pkg::CFG_ADDR_W-1:0] CFG_SPARE_3 = 2'd3;

	// Texel store shadow, size registers and the blended values still owed by the sampler.
	class sampler_scoreboard;
		logic signed [bwts_pkg::VAL_W-1:0] texels [STORE_DEPTH];
		bit                                loaded [STORE_DEPTH];
		logic [bwts_pkg::CFG_DATA_W-1:0]   width_reg;
		logic [bwts_pkg::CFG_DATA_W-1:0]   height_reg;
		logic [bwts_pkg::OUT_W-1:0]        pending_samples [$];
		int                                errors;

		function new();
			width_reg  = 9'd256;
			height_reg = 9'd256;
			errors     = 0;
		endfunction

		// Zero counts as one, anything past the store side is clamped to it
		function int unsigned eff_side(logic [bwts_pkg::CFG_DATA_W-1:0] r);
			if (r == 0)
				return 1;
			if (r > MAX_SIDE)
				return MAX_SIDE;
			return 32'(r);
		endfunction

		// Wrap u and v to their fractions, scale by the sizes, find the four taps and weights
		function void locate(logic [31:0] u, logic [31:0] v,
				output int unsigned tap [bwts_pkg::NUM_TAPS],
				output logic [15:0] dx, output logic [15:0] dy);
			int unsigned w, h, px, py, x0, x1, y0, y1;
			w  = eff_side(width_reg);
			h  = eff_side(height_reg);
			px = u[bwts_pkg::FRAC_W-1:0] * w;
			py = v[bwts_pkg::FRAC_W-1:0] * h;
			x0 = px >> bwts_pkg::FRAC_W;
			y0 = py >> bwts_pkg::FRAC_W;
			dx = px[15:0];
			dy = py[15:0];
			x1 = (x0 + 1 == w) ? 0 : x0 + 1;
			y1 = (y0 + 1 == h) ? 0 : y0 + 1;
			tap[bwts_pkg::TAP_00] = (y0 * w + x0) % STORE_DEPTH;
			tap[bwts_pkg::TAP_10] = (y0 * w + x1) % STORE_DEPTH;
			tap[bwts_pkg::TAP_01] = (y1 * w + x0) % STORE_DEPTH;
			tap[bwts_pkg::TAP_11] = (y1 * w + x1) % STORE_DEPTH;
		endfunction

		// One interpolation stage with floor
		function longint lerp(longint a, longint b, logic [15:0] wt);
			longint wl;
			wl = wt;
			return (a * (65536 - wl) + b * wl) >>> bwts_pkg::FRAC_W;
		endfunction

		function logic [bwts_pkg::OUT_W-1:0] blend_sample(logic [31:0] u, logic [31:0] v);
			int unsigned tap [bwts_pkg::NUM_TAPS];
			logic [15:0] dx, dy;
			longint      row0, row1;
			locate(u, v, tap, dx, dy);
			row0 = lerp(texels[tap[bwts_pkg::TAP_00]], texels[tap[bwts_pkg::TAP_10]], dx);
			row1 = lerp(texels[tap[bwts_pkg::TAP_01]], texels[tap[bwts_pkg::TAP_11]], dx);
			return bwts_pkg::OUT_W'(lerp(row0, row1, dy));
		endfunction

		function void set_reg(logic [bwts_pkg::CFG_ADDR_W-1:0] addr,
				logic [bwts_pkg::CFG_DATA_W-1:0] data);
			if (addr == bwts_pkg::CFG_TEX_WIDTH)
				width_reg = data;
			else if (addr == bwts_pkg::CFG_TEX_HEIGHT)
				height_reg = data;
		endfunction

		function void note_transfer(bwts_pkg::req_t kind, logic [bwts_pkg::IDX_W-1:0] idx,
				logic [bwts_pkg::VAL_W-1:0] val, logic [31:0] u, logic [31:0] v);
			if (kind == bwts_pkg::REQ_WRITE) begin
				if (idx < STORE_DEPTH) begin
					texels[idx] = val;
					loaded[idx] = 1'b1;
				end
			end else begin
				pending_samples.insert(pending_samples.size(), blend_sample(u, v));
			end
		endfunction

		function void check_sample(logic [bwts_pkg::OUT_W-1:0] got);
			logic [bwts_pkg::OUT_W-1:0] want;
			if (pending_samples.size() == 0) begin
				errors++;
				$display("%0t: sample_value expected none, actual %h", $time, got);
			end else begin
				want = pending_samples.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: sample_value expected %h, actual %h", $time, want, got);
				end
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	// tdata, low to high: texel_index, texel_value, u_coord, v_coord
	logic [bwts_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
	// tuser: req_type
	logic [0:0]                      s_tuser   = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	// tdata: sample_value
	logic [bwts_pkg::OUT_W-1:0]      m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [bwts_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [bwts_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	sampler_scoreboard sb = new();
	int                burst_left = 0;
	int                items_sent = 0;
	int                quiet_cycles = 0;

	bilinear_wrap_texel_sampler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [bwts_pkg::VAL_W-1:0] rand_texel();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return bwts_pkg::VAL_W'($urandom);
		endcase
	endfunction

	// Bias fractions toward both edges so the wrapped neighbor gets exercised
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return {16'($urandom), 16'hFFFF - 16'($urandom_range(3))};
			1: return {16'($urandom), 16'($urandom_range(3))};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [bwts_pkg::CFG_DATA_W-1:0] pick_side();
		case ($urandom_range(7))
			0: return 9'd0;
			1: return 9'd1;
			2: return 9'd2;
			3: return 9'd256;
			4: return 9'($urandom_range(511, 257));
			5: return 9'($urandom_range(255, 3));
			default: return 9'($urandom_range(12, 3));
		endcase
	endfunction

	// Drive one item: open a new burst after a random gap when the last one ran out,
	// hold the item until its transfer, then record it in the shadow model.
	task automatic send_item(bwts_pkg::req_t kind, logic [bwts_pkg::IDX_W-1:0] idx,
			logic [bwts_pkg::VAL_W-1:0] val, logic [31:0] u, logic [31:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {v, u, val, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_transfer(kind, idx, val, u, v);
		items_sent++;
		@(negedge clk);
	endtask

	// Texel write; fill the unused coordinate bits with noise
	task automatic send_write(logic [bwts_pkg::IDX_W-1:0] idx, logic [bwts_pkg::VAL_W-1:0] val);
		send_item(bwts_pkg::REQ_WRITE, idx, val, $urandom, $urandom);
	endtask

	// Load any neighbor that was never written, sometimes overwrite one right before
	// the read, then transfer the sample itself.
	task automatic sample_at(logic [31:0] u, logic [31:0] v);
		int unsigned tap [bwts_pkg::NUM_TAPS];
		logic [15:0] dx, dy;
		sb.locate(u, v, tap, dx, dy);
		for (int i = 0; i < bwts_pkg::NUM_TAPS; i++)
			if (!sb.loaded[tap[i]])
				send_write(bwts_pkg::IDX_W'(tap[i]), rand_texel());
		if ($urandom_range(3) == 0)
			send_write(bwts_pkg::IDX_W'(tap[$urandom_range(bwts_pkg::NUM_TAPS - 1)]),
				rand_texel());
		send_item(bwts_pkg::REQ_SAMPLE, bwts_pkg::IDX_W'($urandom),
			bwts_pkg::VAL_W'($urandom), u, v);
	endtask

	// Drop the input valid, wait for every owed sample, then let trailing writes drain
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending_samples.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [bwts_pkg::CFG_ADDR_W-1:0] addr,
			logic [bwts_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(addr, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [bwts_pkg::CFG_DATA_W-1:0] w,
			logic [bwts_pkg::CFG_DATA_W-1:0] h);
		settle();
		write_reg(bwts_pkg::CFG_TEX_WIDTH, w);
		if ($urandom_range(3) == 0)
			write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, 9'($urandom));
		write_reg(bwts_pkg::CFG_TEX_HEIGHT, h);
	endtask

	// Random traffic under the current sizes: mostly samples with their taps loaded,
	// some rewrites inside the active texture, some writes anywhere in the store.
	task automatic random_phase(int count);
		int          first, pick;
		int unsigned w, h;
		first = items_sent;
		w = sb.eff_side(sb.width_reg);
		h = sb.eff_side(sb.height_reg);
		while (items_sent - first < count) begin
			pick = $urandom_range(99);
			if (pick < 70)
				sample_at(rand_coord(), rand_coord());
			else if (pick < 85)
				send_write(bwts_pkg::IDX_W'($urandom_range(h - 1) * w + $urandom_range(w - 1)),
					rand_texel());
			else
				send_write(bwts_pkg::IDX_W'($urandom), rand_texel());
		end
	endtask

	// Result side: stretches of steady accept, coin-flip accept, and long stalls
	initial begin : sink_pattern
		int  mode, stretch, run;
		bit  level;
		level = 1'b0;
		forever begin
			mode    = $urandom_range(2);
			stretch = $urandom_range(200, 20);
			while (stretch > 0) begin
				case (mode)
					0: begin
						level = 1'b1;
						run   = stretch;
					end
					1: begin
						level = $urandom_range(1);
						run   = 1;
					end
					default: begin
						level = !level;
						run   = level ? $urandom_range(4, 1) : $urandom_range(24, 1);
					end
				endcase
				if (run > stretch)
					run = stretch;
				stretch -= run;
				repeat (run) begin
					@(negedge clk);
					m_tready <= level;
				end
			end
		end
	end

	// Check every result transfer against the oldest owed sample
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_sample(m_tdata);
	end

	// Watchdog: end the run once no channel has moved for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset sizes 256 x 256: extreme texel values around the origin
		send_write(16'd0, 16'h7FFF);
		send_write(16'd1, 16'h8000);
		send_write(16'd256, 16'hFFFF);
		send_write(16'd257, 16'h0000);
		send_write(16'd65535, 16'h8000);
		sample_at(32'h0000_0000, 32'h0000_0000);
		sample_at(32'h0000_0080, 32'h0000_0080);
		// Fraction all ones: last column and row, neighbors wrap to zero
		sample_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		sample_at(32'h7FFF_FFFF, 32'h8000_0000);
		sample_at(32'h8000_0001, 32'h7FFF_0040);

		// Zero width acts as one, oversize height clamps; spare indexes do nothing
		configure(9'd0, 9'h1FF);
		write_reg(CFG_SPARE_2, 9'd5);
		write_reg(CFG_SPARE_3, 9'h1FF);
		sample_at(32'h1234_5678, 32'hFFFF_FFFF);
		sample_at(32'hFFFF_8000, 32'h0000_0100);

		// Single texel: all four taps land on the same entry
		configure(9'd1, 9'd1);
		sample_at(32'h9ABC_DEF0, 32'h0000_FFFF);

		// Odd small size with the wrap at the right and bottom edges
		configure(9'd3, 9'd5);
		sample_at(32'h0000_FFFF, 32'hFFFF_FFFF);
		sample_at(32'h0000_5555, 32'h0000_3333);

		// Random phases until the item budget is spent
		while (items_sent < ITEM_TARGET) begin
			configure(pick_side(), pick_side());
			random_phase($urandom_range(90, 50));
		end

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending_samples.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/bwts_pkg.sv
rtl/bwts_addr.sv
rtl/bwts_store.sv
rtl/bwts_blend.sv
rtl/bwts_ofifo.sv
rtl/bilinear_wrap_texel_sampler.sv
sim/tb_bilinear_wrap_texel_sampler.sv
